@@ hdl/slkt_pkg.sv @@
// ----------------------------------------------------------------------------
// slkt_pkg: shared definitions for the sorted leaf key table
// Widths, codes, entry layout and the structs passed between the modules.
// ----------------------------------------------------------------------------
package slkt_pkg;

  localparam int CAPACITY = 256;
  localparam int KEY_BITS = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths of the request and result items.
  localparam int OP_W       = 2;
  localparam int KEY_W      = 64;
  localparam int HDL_W      = 32;
  localparam int LEN_W      = 16;
  localparam int STAT_W     = 2;
  localparam int POS_W      = 9;
  localparam int COUNT_W    = 9;
  localparam int USED_W     = 25;
  localparam int TOTAL_W    = 24;
  localparam int OVH_W      = 8;
  localparam int LIMIT_W    = 16;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 96;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int FULL_NUM = 9;
  localparam int FULL_DEN = 10;

  localparam logic [OVH_W-1:0]   OVH_RST   = OVH_W'(20);
  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(4096 * FULL_NUM / FULL_DEN);

  // Operation codes; the unused code behaves as a lookup.
  localparam logic [OP_W-1:0] OP_LOOKUP = OP_W'(0);
  localparam logic [OP_W-1:0] OP_INSERT = OP_W'(1);
  localparam logic [OP_W-1:0] OP_DELETE = OP_W'(2);

  localparam logic [STAT_W-1:0] ST_DONE   = STAT_W'(0);
  localparam logic [STAT_W-1:0] ST_MISS   = STAT_W'(1);
  localparam logic [STAT_W-1:0] ST_NOROOM = STAT_W'(2);

  localparam logic [CFG_IDX_W-1:0] REG_OVERHEAD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = CFG_IDX_W'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_ACT,
    S_UP,
    S_DN,
    S_INS,
    S_CALC,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [HDL_W-1:0]    hdl;
    logic [LEN_W-1:0]    len;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [POS_W-1:0]   pos;
    logic [HDL_W-1:0]   fh;
    logic [LEN_W-1:0]   fl;
    logic [COUNT_W-1:0] cnt;
    logic [USED_W-1:0]  used;
  } res_t;

endpackage

@@ hdl/sorted_leaf_key_table_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_leaf_key_table_unit: key-sorted entry table with lookup, insert and
// delete
// Holds up to 256 entries of key, value handle and value length in key order
// and answers each request with status, position, count, used bytes and the
// full flag.
// ----------------------------------------------------------------------------
// One request is handled at a time. Each probe of the binary search reads
// the entry in the middle of the window through the single read port of the
// entry memory and compares its key; when the key is absent, a last search
// step finds the window empty. An insert of a new key then moves every entry
// from the insertion point one place up, one entry per cycle, and writes the
// new entry; a delete moves the entries behind the match one place down. A
// decide state picks the action after the search, and after the moves one
// state computes used bytes and one hands over the result; the request is
// taken in the idle state. The hand-over waits while the previous result is
// still held. The finished result sits in an output register, so a new
// request is taken while it waits. Configuration is to be written by the
// user only while the block is idle; the block itself does not enforce it.
module sorted_leaf_key_table_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // key [63:0], value_handle [95:64], value_length [111:96]
  input  logic [slkt_pkg::IN_DATA_W-1:0]   in_tdata,
  // operation [1:0]
  input  logic [slkt_pkg::OP_W-1:0]        in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // position [8:0], found_handle [40:9], found_length [56:41],
  // entry_count [65:57], used_bytes [90:66], is_full [91], zero [95:92]
  output logic [slkt_pkg::OUT_DATA_W-1:0]  out_tdata,
  // status [1:0]
  output logic [slkt_pkg::STAT_W-1:0]      out_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [slkt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slkt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [slkt_pkg::OVH_W-1:0]   ovh_r, ovh_nxt;
  logic [slkt_pkg::LIMIT_W-1:0] limit_r, limit_nxt;
  logic                         out_valid_r;
  slkt_pkg::res_t               out_res_r;
  logic                         out_full_r;

  slkt_pkg::mem_req_t mem_req;
  slkt_pkg::entry_t   rd_data;
  slkt_pkg::res_t     res;
  logic               res_load;
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    ovh_nxt   = ovh_r;
    limit_nxt = limit_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        slkt_pkg::REG_OVERHEAD: ovh_nxt   = cfg_data[slkt_pkg::OVH_W-1:0];
        slkt_pkg::REG_LIMIT:    limit_nxt = cfg_data[slkt_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovh_r       <= slkt_pkg::OVH_RST;
      limit_r     <= slkt_pkg::LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      ovh_r   <= ovh_nxt;
      limit_r <= limit_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r  <= res;
      out_full_r <= res.used > slkt_pkg::USED_W'(limit_r);
    end
  end

  slkt_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  slkt_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .entry_overhead (ovh_r),
    .mem_req        (mem_req),
    .rd_data        (rd_data),
    .out_free       (out_free),
    .res_load       (res_load),
    .res            (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {4'b0000, out_full_r, out_res_r.used, out_res_r.cnt,
                       out_res_r.fl, out_res_r.fh, out_res_r.pos};

endmodule

@@ hdl/slkt_store.sv @@
// ----------------------------------------------------------------------------
// slkt_store: entry memory of the sorted leaf key table
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module slkt_store (
  input  logic               clk,
  input  slkt_pkg::mem_req_t mem_req,
  output slkt_pkg::entry_t   rd_data
);

  slkt_pkg::entry_t mem_q [slkt_pkg::CAPACITY];
  slkt_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem_q[mem_req.wr_addr] <= mem_req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd_data_r <= mem_q[mem_req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/slkt_ctrl.sv @@
// ----------------------------------------------------------------------------
// slkt_ctrl: sequencer of the sorted leaf key table
// Binary search with the key comparators on the entry read back, then entry moves one per
// cycle through the memory ports, then the used-byte figure.
// ----------------------------------------------------------------------------
module slkt_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [slkt_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [slkt_pkg::OP_W-1:0]       in_tuser,
  input  logic [slkt_pkg::OVH_W-1:0]      entry_overhead,
  output slkt_pkg::mem_req_t              mem_req,
  input  slkt_pkg::entry_t                rd_data,
  input  logic                            out_free,
  output logic                            res_load,
  output slkt_pkg::res_t                  res
);

  localparam int CNT_W = slkt_pkg::CNT_W;
  localparam int IDX_W = slkt_pkg::IDX_W;

  slkt_pkg::state_t state_r, state_nxt;

  logic [slkt_pkg::OP_W-1:0]     op_r, op_nxt;
  logic [slkt_pkg::KEY_BITS-1:0] key_r, key_nxt;
  logic [slkt_pkg::HDL_W-1:0]    hdl_r, hdl_nxt;
  logic [slkt_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [CNT_W-1:0]              lo_r, lo_nxt;
  logic [CNT_W-1:0]              hi_r, hi_nxt;
  logic [CNT_W-1:0]              mid_r, mid_nxt;
  logic [CNT_W-1:0]              pos_r, pos_nxt;
  logic [CNT_W-1:0]              i_r, i_nxt;
  logic                          hit_r, hit_nxt;
  logic [slkt_pkg::HDL_W-1:0]    ent_hdl_r, ent_hdl_nxt;
  logic [slkt_pkg::LEN_W-1:0]    ent_len_r, ent_len_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [slkt_pkg::TOTAL_W-1:0]  total_r, total_nxt;
  logic [slkt_pkg::STAT_W-1:0]   status_r, status_nxt;
  logic [slkt_pkg::HDL_W-1:0]    fh_r, fh_nxt;
  logic [slkt_pkg::LEN_W-1:0]    fl_r, fl_nxt;
  logic [slkt_pkg::USED_W-1:0]   used_r, used_nxt;

  logic [CNT_W-1:0]                   mid;
  logic                               probe_go;
  logic                               key_lt;
  logic                               key_gt;
  logic                               is_full_tbl;
  logic                               need_up;
  logic                               need_dn;
  logic                               more_up;
  logic                               more_dn;
  logic [CNT_W+slkt_pkg::OVH_W-1:0]   prod;
  slkt_pkg::entry_t                   new_entry;

  assign mid         = lo_r + ((hi_r - lo_r) >> 1);
  assign probe_go    = lo_r < hi_r;
  assign key_lt      = rd_data.key < key_r;
  assign key_gt      = rd_data.key > key_r;
  assign is_full_tbl = cnt_r >= CNT_W'(slkt_pkg::CAPACITY);
  assign need_up     = pos_r != cnt_r;
  assign need_dn     = (pos_r + CNT_W'(1)) < cnt_r;
  assign more_up     = (i_r - CNT_W'(1)) > pos_r;
  assign more_dn     = (i_r + CNT_W'(2)) < cnt_r;
  assign prod        = (CNT_W + slkt_pkg::OVH_W)'(cnt_r)
                     * (CNT_W + slkt_pkg::OVH_W)'(entry_overhead);
  assign new_entry   = '{key: key_r, hdl: hdl_r, len: len_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      slkt_pkg::S_IDLE: if (in_tvalid) state_nxt = slkt_pkg::S_SRCH;
      slkt_pkg::S_SRCH: state_nxt = probe_go ? slkt_pkg::S_CMP : slkt_pkg::S_ACT;
      slkt_pkg::S_CMP: begin
        if (!key_lt && !key_gt) state_nxt = slkt_pkg::S_ACT;
        else                    state_nxt = slkt_pkg::S_SRCH;
      end
      slkt_pkg::S_ACT: begin
        case (op_r)
          slkt_pkg::OP_INSERT: begin
            if (hit_r || is_full_tbl) state_nxt = slkt_pkg::S_CALC;
            else if (need_up)         state_nxt = slkt_pkg::S_UP;
            else                      state_nxt = slkt_pkg::S_INS;
          end
          slkt_pkg::OP_DELETE: begin
            if (hit_r && need_dn) state_nxt = slkt_pkg::S_DN;
            else                  state_nxt = slkt_pkg::S_CALC;
          end
          default: state_nxt = slkt_pkg::S_CALC;
        endcase
      end
      slkt_pkg::S_UP:   state_nxt = more_up ? slkt_pkg::S_UP : slkt_pkg::S_INS;
      slkt_pkg::S_DN:   state_nxt = more_dn ? slkt_pkg::S_DN : slkt_pkg::S_CALC;
      slkt_pkg::S_INS:  state_nxt = slkt_pkg::S_CALC;
      slkt_pkg::S_CALC: state_nxt = slkt_pkg::S_OUT;
      slkt_pkg::S_OUT:  if (out_free) state_nxt = slkt_pkg::S_IDLE;
      default:          state_nxt = slkt_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    op_nxt      = op_r;
    key_nxt     = key_r;
    hdl_nxt     = hdl_r;
    len_nxt     = len_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    pos_nxt     = pos_r;
    i_nxt       = i_r;
    hit_nxt     = hit_r;
    ent_hdl_nxt = ent_hdl_r;
    ent_len_nxt = ent_len_r;
    cnt_nxt     = cnt_r;
    total_nxt   = total_r;
    status_nxt  = status_r;
    fh_nxt      = fh_r;
    fl_nxt      = fl_r;
    used_nxt    = used_r;
    mem_req     = '0;
    in_tready   = 1'b0;
    res_load    = 1'b0;
    unique case (state_r)
      slkt_pkg::S_IDLE: begin
        in_tready = 1'b1;
        op_nxt    = in_tuser;
        key_nxt   = in_tdata[slkt_pkg::KEY_BITS-1:0];
        hdl_nxt   = in_tdata[slkt_pkg::KEY_W +: slkt_pkg::HDL_W];
        len_nxt   = in_tdata[slkt_pkg::KEY_W+slkt_pkg::HDL_W +: slkt_pkg::LEN_W];
        lo_nxt    = '0;
        hi_nxt    = cnt_r;
        hit_nxt   = 1'b0;
      end
      slkt_pkg::S_SRCH: begin
        if (probe_go) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = mid[IDX_W-1:0];
          mid_nxt         = mid;
        end else begin
          pos_nxt = lo_r;
        end
      end
      slkt_pkg::S_CMP: begin
        if (key_lt) begin
          lo_nxt = mid_r + CNT_W'(1);
        end else if (key_gt) begin
          hi_nxt = mid_r;
        end else begin
          hit_nxt     = 1'b1;
          pos_nxt     = mid_r;
          ent_hdl_nxt = rd_data.hdl;
          ent_len_nxt = rd_data.len;
        end
      end
      slkt_pkg::S_ACT: begin
        status_nxt = slkt_pkg::ST_DONE;
        fh_nxt     = '0;
        fl_nxt     = '0;
        case (op_r)
          slkt_pkg::OP_INSERT: begin
            if (hit_r) begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = pos_r[IDX_W-1:0];
              mem_req.wr_data = new_entry;
              total_nxt = total_r - slkt_pkg::TOTAL_W'(ent_len_r)
                        + slkt_pkg::TOTAL_W'(len_r);
            end else if (is_full_tbl) begin
              status_nxt = slkt_pkg::ST_NOROOM;
            end else if (need_up) begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = IDX_W'(cnt_r - CNT_W'(1));
              i_nxt           = cnt_r;
            end
          end
          slkt_pkg::OP_DELETE: begin
            if (!hit_r) begin
              status_nxt = slkt_pkg::ST_MISS;
            end else begin
              total_nxt = total_r - slkt_pkg::TOTAL_W'(ent_len_r);
              if (need_dn) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = IDX_W'(pos_r + CNT_W'(1));
                i_nxt           = pos_r;
              end else begin
                cnt_nxt = cnt_r - CNT_W'(1);
              end
            end
          end
          default: begin
            if (hit_r) begin
              fh_nxt = ent_hdl_r;
              fl_nxt = ent_len_r;
            end else begin
              status_nxt = slkt_pkg::ST_MISS;
            end
          end
        endcase
      end
      slkt_pkg::S_UP: begin
        // The entry read last cycle moves one place up; the next read is issued alongside.
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = i_r[IDX_W-1:0];
        mem_req.wr_data = rd_data;
        if (more_up) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = IDX_W'(i_r - CNT_W'(2));
          i_nxt           = i_r - CNT_W'(1);
        end
      end
      slkt_pkg::S_DN: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = i_r[IDX_W-1:0];
        mem_req.wr_data = rd_data;
        if (more_dn) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = IDX_W'(i_r + CNT_W'(2));
          i_nxt           = i_r + CNT_W'(1);
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      slkt_pkg::S_INS: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = pos_r[IDX_W-1:0];
        mem_req.wr_data = new_entry;
        cnt_nxt         = cnt_r + CNT_W'(1);
        total_nxt       = total_r + slkt_pkg::TOTAL_W'(len_r);
      end
      slkt_pkg::S_CALC: begin
        used_nxt = slkt_pkg::USED_W'(prod) + slkt_pkg::USED_W'(total_r);
      end
      slkt_pkg::S_OUT: begin
        res_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slkt_pkg::S_IDLE;
      cnt_r   <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    hdl_r     <= hdl_nxt;
    len_r     <= len_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    pos_r     <= pos_nxt;
    i_r       <= i_nxt;
    hit_r     <= hit_nxt;
    ent_hdl_r <= ent_hdl_nxt;
    ent_len_r <= ent_len_nxt;
    status_r  <= status_nxt;
    fh_r      <= fh_nxt;
    fl_r      <= fl_nxt;
    used_r    <= used_nxt;
  end

  assign res.status = status_r;
  assign res.pos    = slkt_pkg::POS_W'(pos_r);
  assign res.fh     = fh_r;
  assign res.fl     = fl_r;
  assign res.cnt    = slkt_pkg::COUNT_W'(cnt_r);
  assign res.used   = used_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(slkt_pkg::CAPACITY))
    else $error("entry count exceeds the table capacity");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == slkt_pkg::S_SRCH) |-> (lo_r <= hi_r))
    else $error("search window inverted");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == slkt_pkg::S_SRCH))
    else $error("accepted request did not start a search");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (cnt_r != $past(cnt_r))) |->
      ((cnt_r == $past(cnt_r) + CNT_W'(1)) || (cnt_r + CNT_W'(1) == $past(cnt_r))))
    else $error("entry count moved by more than one");

  a_cnt_source: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (cnt_r != $past(cnt_r))) |->
      (($past(state_r) == slkt_pkg::S_INS) || ($past(state_r) == slkt_pkg::S_DN)
       || ($past(state_r) == slkt_pkg::S_ACT)))
    else $error("entry count changed outside insert or delete");
`endif

endmodule
